FILE: hdl/kot_pkg.sv
`default_nettype none

package kot_pkg;

    // Number of slots in the table.
    localparam int TABLE_DEPTH = 64;

    // Widths of a slot index and of the live count (which can reach TABLE_DEPTH).
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Field widths of the stream items.
    localparam int OPCODE_W = 2;
    localparam int SESS_W   = 8;
    localparam int KIND_W   = 5;
    localparam int HANDLE_W = 64;
    localparam int REF_W    = 64;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 7;

    // The count is reported through its low LIVE_W bits.
    localparam int LIVE_X_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FORGET = 2'd3
    } kot_op_t;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } kot_state_t;

    // One table entry as held by a cell.
    typedef struct packed {
        logic [SESS_W-1:0]   owner;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [REF_W-1:0]    obj_ref;
    } kot_entry_t;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic             shift;   // one rotation step of the live segment
        logic             feed;    // the head entry is kept and goes to the segment tail
        logic             append;  // the new entry is written at slot count
        logic [CNT_W-1:0] count;   // live count before this cycle
    } kot_cell_ctrl_t;

    function automatic logic [LIVE_W-1:0] to_live(input logic [CNT_W-1:0] cnt);
        logic [LIVE_X_W-1:0] wide;
        wide = LIVE_X_W'(cnt);
        return wide[LIVE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/keyed_object_table.sv
// An operation, once its input transfer is taken, runs n rotation steps of the cell chain, where n
// is the live count when it is accepted (0 to 64); the steps present one live entry a cycle at the
// head cell. The scan state then closes the scan, and the finish state appends and registers the
// result once the output register is free. A request is taken only from the idle state, so no new
// operation starts before the last ends; a result held back by the receiver delays the next one.
// Reset (rst_n, asynchronous, active low) clears the live count; cells need no clearing pass.
`default_nettype none

module keyed_object_table (
    input  wire          clk,
    input  wire          rst_n,

    // Request stream.
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, from bit 0 up: session_id[7:0], object_kind[12:8], wire_handle[76:13],
    // object_ref[140:77], zero padding[143:141].
    input  wire [143:0]  s_axis_tdata,
    // tuser: opcode[1:0].
    input  wire [1:0]    s_axis_tuser,

    // Result stream.
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata, from bit 0 up: found_ref[63:0], live_entries[70:64], zero padding[71].
    output logic [71:0]  m_axis_tdata,
    // tuser: status[1:0].
    output logic [1:0]   m_axis_tuser
);
    import kot_pkg::*;

    // The table lives in a chain of cells, one slot each. Live entries always occupy
    // slots 0 to count-1. During a scan the live segment rotates by one slot a cycle:
    // every live slot takes its upper neighbor and the last live slot takes back the
    // head entry, possibly with its reference replaced by an insert. A dropped head is
    // simply not fed back, which shrinks the segment and keeps it contiguous. Keys are
    // unique in the table, so the order of the entries never shows in any result.

    kot_entry_t     cell_entry [TABLE_DEPTH];
    kot_entry_t     feed_entry;
    kot_entry_t     new_entry;
    kot_cell_ctrl_t cell_ctrl;

    logic [STATUS_W-1:0] out_status;
    logic [REF_W-1:0]    out_ref;
    logic [LIVE_W-1:0]   out_live;

    kot_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (kot_op_t'(s_axis_tuser)),
        .in_sess    (s_axis_tdata[7:0]),
        .in_kind    (s_axis_tdata[12:8]),
        .in_handle  (s_axis_tdata[76:13]),
        .in_ref     (s_axis_tdata[140:77]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_ref    (out_ref),
        .out_live   (out_live),
        .head_entry (cell_entry[0]),
        .feed_entry (feed_entry),
        .new_entry  (new_entry),
        .cell_ctrl  (cell_ctrl)
    );

    // The topmost cell has no upper neighbor; it never shifts, so its input is a constant.
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            kot_entry_t neighbor;
            if (g == TABLE_DEPTH - 1)
            begin : g_top
                assign neighbor = '0;
            end
            else
            begin : g_mid
                assign neighbor = cell_entry[g + 1];
            end

            kot_cell u_cell (
                .clk            (clk),
                .slot_index     (IDX_W'(g)),
                .ctrl           (cell_ctrl),
                .head_entry     (feed_entry),
                .neighbor_entry (neighbor),
                .new_entry      (new_entry),
                .entry          (cell_entry[g])
            );
        end
    endgenerate

    assign m_axis_tdata = {1'b0, out_live, out_ref};
    assign m_axis_tuser = out_status;

    // The live count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.count <= CNT_W'(TABLE_DEPTH))
    else $error("live count exceeds the table depth");

    // An append only happens into a table with room, and never during a rotation step.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.append |-> (cell_ctrl.count < CNT_W'(TABLE_DEPTH)) && !cell_ctrl.shift)
    else $error("append into a full table or during a scan step");

    // No rotation step runs in the cycle a request is taken, and the count holds then.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !cell_ctrl.shift ##1 $stable(cell_ctrl.count))
    else $error("table changed while a request was being taken");

    // A result never carries the unused status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK) || (m_axis_tuser == STAT_NOT_FOUND) ||
                          (m_axis_tuser == STAT_FULL))
    else $error("result carries an undefined status");

endmodule

`default_nettype wire

FILE: hdl/kot_cell.sv
`default_nettype none

module kot_cell (
    input  wire                      clk,
    input  wire [kot_pkg::IDX_W-1:0] slot_index,
    input  kot_pkg::kot_cell_ctrl_t  ctrl,
    input  kot_pkg::kot_entry_t      head_entry,
    input  kot_pkg::kot_entry_t      neighbor_entry,
    input  kot_pkg::kot_entry_t      new_entry,
    output kot_pkg::kot_entry_t      entry
);
    import kot_pkg::*;

    kot_entry_t       entry_reg;
    kot_entry_t       entry_next;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_plus;

    assign idx_ext  = CNT_W'(slot_index);
    assign idx_plus = CNT_W'(idx_ext + CNT_W'(1));

    // During a step, slots inside the live segment take their upper neighbor;
    // the last live slot takes the head back unless the head is dropped.
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.shift && (idx_plus < ctrl.count))
        begin
            entry_next = neighbor_entry;
        end
        else if (ctrl.shift && ctrl.feed && (idx_plus == ctrl.count))
        begin
            entry_next = head_entry;
        end
        else if (ctrl.append && (idx_ext == ctrl.count))
        begin
            entry_next = new_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: hdl/kot_ctrl.sv
`default_nettype none

module kot_ctrl (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  kot_pkg::kot_op_t            in_op,
    input  wire [kot_pkg::SESS_W-1:0]   in_sess,
    input  wire [kot_pkg::KIND_W-1:0]   in_kind,
    input  wire [kot_pkg::HANDLE_W-1:0] in_handle,
    input  wire [kot_pkg::REF_W-1:0]    in_ref,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [kot_pkg::STATUS_W-1:0] out_status,
    output logic [kot_pkg::REF_W-1:0]   out_ref,
    output logic [kot_pkg::LIVE_W-1:0]  out_live,
    input  kot_pkg::kot_entry_t         head_entry,
    output kot_pkg::kot_entry_t         feed_entry,
    output kot_pkg::kot_entry_t         new_entry,
    output kot_pkg::kot_cell_ctrl_t     cell_ctrl
);
    import kot_pkg::*;

    kot_state_t          state_reg;
    kot_state_t          state_next;

    kot_op_t             op_reg;
    logic [SESS_W-1:0]   sess_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [REF_W-1:0]    ref_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    remain_reg;
    logic [CNT_W-1:0]    remain_next;
    logic                hit_reg;
    logic                hit_next;
    logic [REF_W-1:0]    found_reg;
    logic [REF_W-1:0]    found_next;

    logic                oval_reg;
    logic                oval_next;
    logic [STATUS_W-1:0] ostat_reg;
    logic [STATUS_W-1:0] ostat_next;
    logic [REF_W-1:0]    oref_reg;
    logic [REF_W-1:0]    oref_next;
    logic [LIVE_W-1:0]   olive_reg;
    logic [LIVE_W-1:0]   olive_next;

    logic                accept;
    logic                step;
    logic                finish;
    logic                out_free;
    logic                key_match;
    logic                drop;
    logic                table_full;
    logic                do_append;

    assign out_free   = !oval_reg || out_ready;
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (remain_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State decoded outputs.
    always_comb
    begin
        in_ready = 1'b0;
        step     = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                step = (remain_reg != '0);
            end
            ST_FINISH:
            begin
                finish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // One head entry is examined per step.
    always_comb
    begin
        key_match = (head_entry.owner == sess_reg) && (head_entry.kind == kind_reg) &&
                    (head_entry.handle == handle_reg);
        drop      = ((op_reg == OP_REMOVE) && key_match) ||
                    ((op_reg == OP_FORGET) && (head_entry.owner == sess_reg));
        feed_entry = head_entry;
        if ((op_reg == OP_INSERT) && key_match)
        begin
            feed_entry.obj_ref = ref_reg;
        end
        do_append = finish && (op_reg == OP_INSERT) && !hit_reg && !table_full;
    end

    assign new_entry = '{owner: sess_reg, kind: kind_reg, handle: handle_reg, obj_ref: ref_reg};

    assign cell_ctrl = '{shift: step, feed: !drop, append: do_append, count: count_reg};

    always_comb
    begin
        count_next  = count_reg;
        remain_next = remain_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        oval_next   = oval_reg;
        ostat_next  = ostat_reg;
        oref_next   = oref_reg;
        olive_next  = olive_reg;

        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end

        if (accept)
        begin
            remain_next = count_reg;
            hit_next    = 1'b0;
            found_next  = '0;
        end

        if (step)
        begin
            remain_next = CNT_W'(remain_reg - CNT_W'(1));
            if (drop)
            begin
                count_next = CNT_W'(count_reg - CNT_W'(1));
            end
            if (key_match && (op_reg != OP_FORGET))
            begin
                hit_next = 1'b1;
                if (op_reg == OP_LOOKUP)
                begin
                    found_next = head_entry.obj_ref;
                end
            end
        end

        if (finish)
        begin
            oval_next = 1'b1;
            oref_next = '0;
            if (do_append)
            begin
                count_next = CNT_W'(count_reg + CNT_W'(1));
            end
            unique case (op_reg)
                OP_INSERT:
                begin
                    ostat_next = (hit_reg || !table_full) ? STAT_OK : STAT_FULL;
                end
                OP_LOOKUP:
                begin
                    ostat_next = hit_reg ? STAT_OK : STAT_NOT_FOUND;
                    oref_next  = found_reg;
                end
                OP_REMOVE:
                begin
                    ostat_next = hit_reg ? STAT_OK : STAT_NOT_FOUND;
                end
                OP_FORGET:
                begin
                    ostat_next = STAT_OK;
                end
                default:
                begin
                    ostat_next = STAT_OK;
                end
            endcase
            olive_next = to_live(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            hit_reg    <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            hit_reg    <= hit_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_op;
            sess_reg   <= in_sess;
            kind_reg   <= in_kind;
            handle_reg <= in_handle;
            ref_reg    <= in_ref;
        end
        found_reg <= found_next;
        ostat_reg <= ostat_next;
        oref_reg  <= oref_next;
        olive_reg <= olive_next;
    end

    assign out_valid  = oval_reg;
    assign out_status = ostat_reg;
    assign out_ref    = oref_reg;
    assign out_live   = olive_reg;

endmodule

`default_nettype wire
